### hw/rtl/mm3_pkg.sv
// Shared types, constants and helpers for the MurmurHash3 byte stream hash.
package mm3_pkg;

    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_N  = 32'he6546b64;
    localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef struct packed {
        logic        load_seed;
        logic [31:0] seed;
        logic        do_block;
        logic [31:0] block;
        logic        do_final;
        logic        has_tail;
        logic [23:0] tail;
        logic [31:0] length;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCR_C1,
        ST_SCR_C2,
        ST_BLK_MIX,
        ST_TAIL_MIX,
        ST_FIN_LEN,
        ST_FIN_M1,
        ST_FIN_M2,
        ST_FIN_OUT
    } back_state_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

    function automatic logic [31:0] xorshift16(input logic [31:0] v);
        return v ^ {16'd0, v[31:16]};
    endfunction

    function automatic logic [31:0] xorshift13(input logic [31:0] v);
        return v ^ {13'd0, v[31:13]};
    endfunction

endpackage

### hw/rtl/murmur3_32_byte_stream_hash.sv
// Top level of the MurmurHash3 x86 32-bit byte stream hash.
// Input: one byte request per cycle while the command queue has room.
// 4-byte blocks mix on the shared multiplier; bytes stream at 1/cycle while queue has room.
// out_valid is set in ST_FIN_OUT, after ST_FIN_LEN, ST_FIN_M1 and ST_FIN_M2;
// a final block and a tail are mixed first if present; queued commands and out_stall delay it.
// Reset (rst_n low, async) clears the hash, gatherer, length, queue and output valid.
module murmur3_32_byte_stream_hash
#(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] seed,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        first,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] hash_value
);

    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;
    mm3_pkg::cmd_t push_cmd;
    mm3_pkg::cmd_t head_cmd;

    mm3_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .seed      (seed),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .first     (first),
        .last      (last),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full)
    );

    mm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    mm3_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

endmodule

### hw/rtl/mm3_front.sv
// Front end: takes byte requests, gathers blocks, counts length, issues commands.
module mm3_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         seed,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                first,
    input  logic                last,
    output logic                push,
    output mm3_pkg::cmd_t       push_cmd,
    input  logic                full
);

    logic [23:0] pend_reg;
    logic [23:0] pend_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;

    logic [23:0] pend_cur;
    logic [1:0]  phase_cur;
    logic [31:0] len_cur;
    logic        accept;
    mm3_pkg::cmd_t cmd;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    always_comb
    begin
        pend_cur   = first ? 24'd0 : pend_reg;
        phase_cur  = first ? 2'd0 : phase_reg;
        len_cur    = first ? 32'd0 : len_reg;
        pend_next  = pend_cur;
        phase_next = phase_cur;
        len_next   = len_cur;

        cmd           = '0;
        cmd.load_seed = first;
        cmd.seed      = seed;

        if (has_byte)
        begin
            len_next = len_cur + 32'd1;
            if (phase_cur == mm3_pkg::PHASE_LAST)
            begin
                cmd.do_block = 1'b1;
                cmd.block    = {data_byte, pend_cur};
                pend_next    = 24'd0;
                phase_next   = 2'd0;
            end
            else
            begin
                case (phase_cur)
                    2'd0:    pend_next[7:0]   = data_byte;
                    2'd1:    pend_next[15:8]  = data_byte;
                    default: pend_next[23:16] = data_byte;
                endcase
                phase_next = phase_cur + 2'd1;
            end
        end

        if (last)
        begin
            cmd.do_final = 1'b1;
            cmd.has_tail = (phase_next != 2'd0);
            cmd.tail     = pend_next;
            cmd.length   = len_next;
            pend_next    = 24'd0;
            phase_next   = 2'd0;
            len_next     = 32'd0;
        end
    end

    assign push     = accept && (cmd.load_seed || cmd.do_block || cmd.do_final);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            phase_reg <= '0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (phase_reg == 2'd0 && len_reg == 32'd0 && pend_reg == 24'd0))
        else $error("gatherer not cleared after last request");

endmodule

### hw/rtl/mm3_queue.sv
// Short command queue between the front end and the mixing engine.
module mm3_queue
#(
    parameter int DEPTH = mm3_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mm3_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output mm3_pkg::cmd_t head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mm3_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");

endmodule

### hw/rtl/mm3_back.sv
// Mixing engine: block mix, tail mix and finalizer on one shared multiplier.
module mm3_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  mm3_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [31:0]   hash_value
);

    mm3_pkg::back_state_t state_reg;
    mm3_pkg::back_state_t state_next;
    logic [31:0]   h_reg;
    logic [31:0]   h_next;
    logic [31:0]   x_reg;
    logic [31:0]   x_next;
    logic          tail_mode_reg;
    logic          tail_mode_next;
    mm3_pkg::cmd_t cmd_reg;
    mm3_pkg::cmd_t cmd_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   hash_reg;
    logic [31:0]   hash_next;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [31:0]   mul_p;
    logic [31:0]   mixed;
    logic [31:0]   fin_v;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        tail_mode_next = tail_mode_reg;
        cmd_next       = cmd_reg;
        hash_next      = hash_reg;
        pop            = 1'b0;
        mul_a          = x_reg;
        mul_b          = mm3_pkg::MIX_C1;
        mixed          = mm3_pkg::rotl13(h_reg ^ x_reg);
        fin_v          = mm3_pkg::xorshift16(h_reg);

        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            mm3_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    if (head_cmd.load_seed)
                    begin
                        h_next = head_cmd.seed;
                    end
                    if (head_cmd.do_block)
                    begin
                        x_next         = head_cmd.block;
                        tail_mode_next = 1'b0;
                        state_next     = mm3_pkg::ST_SCR_C1;
                    end
                    else if (head_cmd.do_final && head_cmd.has_tail)
                    begin
                        x_next         = {8'd0, head_cmd.tail};
                        tail_mode_next = 1'b1;
                        state_next     = mm3_pkg::ST_SCR_C1;
                    end
                    else if (head_cmd.do_final)
                    begin
                        state_next = mm3_pkg::ST_FIN_LEN;
                    end
                end
            end
            mm3_pkg::ST_SCR_C1:
            begin
                mul_a      = x_reg;
                mul_b      = mm3_pkg::MIX_C1;
                x_next     = mm3_pkg::rotl15(mul_p);
                state_next = mm3_pkg::ST_SCR_C2;
            end
            mm3_pkg::ST_SCR_C2:
            begin
                mul_a      = x_reg;
                mul_b      = mm3_pkg::MIX_C2;
                x_next     = mul_p;
                state_next = tail_mode_reg ? mm3_pkg::ST_TAIL_MIX : mm3_pkg::ST_BLK_MIX;
            end
            mm3_pkg::ST_BLK_MIX:
            begin
                h_next = {mixed[29:0], 2'b00} + mixed + mm3_pkg::MIX_N;
                if (cmd_reg.do_final && cmd_reg.has_tail)
                begin
                    x_next         = {8'd0, cmd_reg.tail};
                    tail_mode_next = 1'b1;
                    state_next     = mm3_pkg::ST_SCR_C1;
                end
                else if (cmd_reg.do_final)
                begin
                    state_next = mm3_pkg::ST_FIN_LEN;
                end
                else
                begin
                    state_next = mm3_pkg::ST_IDLE;
                end
            end
            mm3_pkg::ST_TAIL_MIX:
            begin
                h_next     = h_reg ^ x_reg;
                state_next = mm3_pkg::ST_FIN_LEN;
            end
            mm3_pkg::ST_FIN_LEN:
            begin
                h_next     = mm3_pkg::xorshift16(h_reg ^ cmd_reg.length);
                state_next = mm3_pkg::ST_FIN_M1;
            end
            mm3_pkg::ST_FIN_M1:
            begin
                mul_a      = h_reg;
                mul_b      = mm3_pkg::FIN_M1;
                h_next     = mul_p;
                state_next = mm3_pkg::ST_FIN_M2;
            end
            mm3_pkg::ST_FIN_M2:
            begin
                mul_a      = mm3_pkg::xorshift13(h_reg);
                mul_b      = mm3_pkg::FIN_M2;
                h_next     = mul_p;
                state_next = mm3_pkg::ST_FIN_OUT;
            end
            mm3_pkg::ST_FIN_OUT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    hash_next      = fin_v;
                    h_next         = fin_v;
                    state_next     = mm3_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mm3_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mm3_pkg::ST_IDLE;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
            tail_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
            tail_mode_reg <= tail_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        cmd_reg  <= cmd_next;
        hash_reg <= hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mm3_pkg::ST_FIN_OUT && !(out_valid_reg && out_stall))
        |=> (out_valid_reg && state_reg == mm3_pkg::ST_IDLE && hash_reg == h_reg))
        else $error("finalized hash not emitted");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mm3_pkg::ST_IDLE) |-> !pop)
        else $error("command popped while busy");

endmodule
